// ----- src/positional_array_insert_delete_search_macros.svh -----
// ----------------------------------------------------------------------------
// Positional array assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH

// Check that a condition holds at every clock edge.
`define PA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a consequent holds whenever the antecedent holds.
`define PA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/posarr_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional array package
// Operation, status and cell command codes, field widths and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package posarr_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int WORD_W        = 32;
  localparam int IDX_W         = 7;
  localparam int CNT_W         = 8;
  localparam int OP_W          = 3;
  localparam int ST_W          = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_LOAD   = 3'd4,
    CMD_SHIFT  = 3'd5
  } cell_cmd_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    cell_cmd_e         cmd;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/posarr_cell.sv -----
// ----------------------------------------------------------------------------
// Positional array cell
// Holds one entry and one scan copy; shifts with its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module posarr_cell #(
  parameter int CW  = 8,
  parameter int POS = 0
) (
  input  wire                        clk_i,
  input  posarr_pkg::cell_ctrl_t     ctrl_i,
  input  wire  [CW-1:0]              pos_i,
  input  wire  [posarr_pkg::WORD_W-1:0] left_i,
  input  wire  [posarr_pkg::WORD_W-1:0] right_i,
  input  wire  [posarr_pkg::WORD_W-1:0] scan_right_i,
  output logic [posarr_pkg::WORD_W-1:0] entry_o,
  output logic [posarr_pkg::WORD_W-1:0] scan_o
);
  import posarr_pkg::*;

  localparam logic [CW-1:0] MyPos = CW'(POS);

  logic [WORD_W-1:0] entry_q, entry_d;
  logic [WORD_W-1:0] scan_q, scan_d;

  always_comb begin
    entry_d = entry_q;
    scan_d  = scan_q;
    case (ctrl_i.cmd)
      CMD_APPEND: begin
        if (MyPos == pos_i) entry_d = ctrl_i.value;
      end
      CMD_INSERT: begin
        if (MyPos > pos_i) begin
          entry_d = left_i;
        end else if (MyPos == pos_i) begin
          entry_d = ctrl_i.value;
        end
      end
      CMD_DELETE: begin
        if (MyPos >= pos_i) entry_d = right_i;
      end
      CMD_LOAD:  scan_d = entry_q;
      CMD_SHIFT: scan_d = scan_right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    scan_q  <= scan_d;
  end

  assign entry_o = entry_q;
  assign scan_o  = scan_q;

endmodule

`default_nettype wire

// ----- src/posarr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Positional array controller
// Decodes transactions, keeps the count, steps the scan and forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module posarr_ctrl #(
  parameter int DEPTH = posarr_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire  [posarr_pkg::OP_W-1:0]   operation_i,
  input  wire  [posarr_pkg::IDX_W-1:0]  index_i,
  input  wire  [posarr_pkg::WORD_W-1:0] value_i,
  input  wire  [posarr_pkg::WORD_W-1:0] head_i,
  output posarr_pkg::cell_ctrl_t        ctrl_o,
  output logic [CW-1:0]                 pos_o,
  output logic                          done_o,
  output logic [posarr_pkg::ST_W-1:0]   status_o,
  output logic [posarr_pkg::IDX_W-1:0]  found_index_o,
  output logic [posarr_pkg::WORD_W-1:0] read_value_o,
  output logic [posarr_pkg::CNT_W-1:0]  count_o
);
  import posarr_pkg::*;
  `include "positional_array_insert_delete_search_macros.svh"

  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] CntMax = CW'(DEPTH);
  localparam logic [CW-1:0] CntOne = CW'(1);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     k_q, k_d;
  op_e               op_q, op_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [WORD_W-1:0] key_q, key_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [IDX_W-1:0]  found_q, found_d;
  logic [WORD_W-1:0] rd_q, rd_d;

  logic [XW-1:0] idx_x, cnt_x;
  logic          accept, empty, full, go_scan, scan_end;
  logic          hit, at_idx, last;

  assign idx_x  = XW'(index_i);
  assign cnt_x  = XW'(count_q);
  assign accept = start && (state_q == S_IDLE);
  assign empty  = (count_q == '0);
  assign full   = (count_q == CntMax);
  assign hit    = (head_i == key_q);
  assign at_idx = (k_q == idx_q);
  assign last   = (k_q == count_q - CntOne);

  always_comb begin
    go_scan = 1'b0;
    case (op_e'(operation_i))
      OP_DELETE, OP_READ: go_scan = !empty && (idx_x < cnt_x);
      OP_SEARCH:          go_scan = !empty;
      default:            go_scan = 1'b0;
    endcase
    if (op_q == OP_SEARCH) begin
      scan_end = hit || last;
    end else begin
      scan_end = at_idx;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && go_scan) state_d = S_SCAN;
      S_SCAN:  if (scan_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.cmd   = CMD_HOLD;
    ctrl_o.value = value_i;
    pos_o        = count_q;
    count_d      = count_q;
    k_d          = k_q;
    op_d         = op_q;
    idx_d        = idx_q;
    key_d        = key_q;
    done_d       = 1'b0;
    status_d     = status_q;
    found_d      = found_q;
    rd_d         = rd_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          found_d  = '0;
          rd_d     = '0;
          op_d     = op_e'(operation_i);
          idx_d    = CW'(index_i);
          key_d    = value_i;
          k_d      = '0;
          done_d   = !go_scan;
          case (op_e'(operation_i))
            OP_CLEAR: count_d = '0;
            OP_APPEND: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl_o.cmd = CMD_APPEND;
                count_d    = count_q + CntOne;
              end
            end
            OP_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else if (idx_x > cnt_x) begin
                status_d = ST_BADIDX;
              end else begin
                ctrl_o.cmd = CMD_INSERT;
                pos_o      = CW'(index_i);
                count_d    = count_q + CntOne;
              end
            end
            OP_DELETE, OP_READ, OP_SEARCH: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else if (go_scan) begin
                ctrl_o.cmd = CMD_LOAD;
              end else begin
                status_d = ST_BADIDX;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          done_d = 1'b1;
          if (op_q == OP_SEARCH) begin
            if (hit) begin
              found_d = IDX_W'(k_q);
            end else begin
              status_d = ST_NOTFOUND;
            end
          end else begin
            rd_d = head_i;
            if (op_q == OP_DELETE) begin
              ctrl_o.cmd = CMD_DELETE;
              pos_o      = idx_q;
              count_d    = count_q - CntOne;
            end
          end
        end else begin
          ctrl_o.cmd = CMD_SHIFT;
          k_d        = k_q + CntOne;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    key_q    <= key_d;
    status_q <= status_d;
    found_q  <= found_d;
    rd_q     <= rd_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign read_value_o  = rd_q;
  assign count_o       = CNT_W'(count_q);

  `PA_ASSERT(a_count_range, count_q <= CntMax, "entry count above depth")
  `PA_ASSERT_IMPL(a_done_idle, done_q, state_q == S_IDLE, "result strobe while scanning")
  `PA_ASSERT_IMPL(a_full_count, done_q && (status_q == ST_FULL), count_q == CntMax,
                  "full status with free entries")
  `PA_ASSERT_IMPL(a_scan_bound, state_q == S_SCAN, k_q < count_q, "scan past last entry")

endmodule

`default_nettype wire

// ----- src/positional_array_insert_delete_search.sv -----
// ----------------------------------------------------------------------------
// Positional array with insert, delete, search and read
// Packed array of signed words held in a chain of cells, one word per cell.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears on the result ports for one cycle with done_o high and
// cannot be held off. Clear, append, insert and any rejected operation
// return their result in the next cycle, with busy staying low. Read,
// delete and search scan the array, with busy high meanwhile; their length
// is set by the scan copy of the cell chain, which moves one cell per cycle
// toward cell 0, where the only read port and key comparator sit.
`default_nettype none

module positional_array_insert_delete_search #(
  parameter int DEPTH = posarr_pkg::DEPTH_DEFAULT
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire  [posarr_pkg::OP_W-1:0]   operation_i,
  input  wire  [posarr_pkg::IDX_W-1:0]  index_i,
  input  wire  [posarr_pkg::WORD_W-1:0] value_i,
  output logic                          done_o,
  output logic [posarr_pkg::ST_W-1:0]   status_o,
  output logic [posarr_pkg::IDX_W-1:0]  found_index_o,
  output logic [posarr_pkg::WORD_W-1:0] read_value_o,
  output logic [posarr_pkg::CNT_W-1:0]  count_o
);
  import posarr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  cell_ctrl_t        ctrl;
  logic [CW-1:0]     pos;
  logic [WORD_W-1:0] entry_w [DEPTH];
  logic [WORD_W-1:0] scan_w  [DEPTH];

  posarr_ctrl #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .head_i       (scan_w[0]),
    .ctrl_o       (ctrl),
    .pos_o        (pos),
    .done_o       (done_o),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w, scan_right_w;

    if (i == 0) begin : g_first
      assign left_w = entry_w[0];
    end else begin : g_inner_l
      assign left_w = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w      = entry_w[i];
      assign scan_right_w = scan_w[i];
    end else begin : g_inner_r
      assign right_w      = entry_w[i+1];
      assign scan_right_w = scan_w[i+1];
    end

    posarr_cell #(
      .CW (CW),
      .POS(i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .pos_i       (pos),
      .left_i      (left_w),
      .right_i     (right_w),
      .scan_right_i(scan_right_w),
      .entry_o     (entry_w[i]),
      .scan_o      (scan_w[i])
    );
  end

endmodule

`default_nettype wire

// ----- test/positional_array_insert_delete_search_checker.sv -----
// ----------------------------------------------------------------------------
// Positional array checker
// Watches the command and result ports, keeps its own copy of the array and
// its count, predicts the outcome of each accepted transaction and compares
// every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module positional_array_insert_delete_search_checker #(
  parameter int DEPTH = posarr_pkg::DEPTH_DEFAULT
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire                           busy_i,
  input  wire  [posarr_pkg::OP_W-1:0]   operation_i,
  input  wire  [posarr_pkg::IDX_W-1:0]  index_i,
  input  wire  [posarr_pkg::WORD_W-1:0] value_i,
  input  wire                           done_i,
  input  wire  [posarr_pkg::ST_W-1:0]   status_i,
  input  wire  [posarr_pkg::IDX_W-1:0]  found_index_i,
  input  wire  [posarr_pkg::WORD_W-1:0] read_value_i,
  input  wire  [posarr_pkg::CNT_W-1:0]  count_i,
  output int                            mismatches_o,
  output int                            pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import posarr_pkg::*;

  typedef struct {
    status_e           status;
    logic [IDX_W-1:0]  found;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
  } outcome_t;

  logic [WORD_W-1:0] words [DEPTH];
  int                word_count;
  outcome_t          outcome_q [$];
  outcome_t          oldest;

  task automatic report(input string what, input logic [WORD_W-1:0] got,
                        input logic [WORD_W-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches_o++;
  endtask

  function automatic outcome_t predict_outcome(input logic [OP_W-1:0] op,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [WORD_W-1:0] key);
    outcome_t o;
    int       i;
    int       pos;
    bit       hit;
    o.status = ST_OK;
    o.found  = '0;
    o.word   = '0;
    pos      = int'(idx);
    hit      = 1'b0;
    case (op)
      OP_CLEAR: begin
        word_count = 0;
      end
      OP_APPEND: begin
        if (word_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          words[word_count] = key;
          word_count++;
        end
      end
      OP_INSERT: begin
        if (word_count >= DEPTH) begin
          o.status = ST_FULL;
        end else if (pos > word_count) begin
          o.status = ST_BADIDX;
        end else begin
          for (i = word_count; i > pos; i--) words[i] = words[i-1];
          words[pos] = key;
          word_count++;
        end
      end
      OP_DELETE: begin
        if (word_count == 0) begin
          o.status = ST_EMPTY;
        end else if (pos >= word_count) begin
          o.status = ST_BADIDX;
        end else begin
          o.word = words[pos];
          for (i = pos; i + 1 < word_count; i++) words[i] = words[i+1];
          word_count--;
        end
      end
      OP_SEARCH: begin
        if (word_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          for (i = 0; i < word_count && !hit; i++) begin
            if (words[i] == key) begin
              o.found = IDX_W'(i);
              hit = 1'b1;
            end
          end
          if (!hit) o.status = ST_NOTFOUND;
        end
      end
      OP_READ: begin
        if (word_count == 0) begin
          o.status = ST_EMPTY;
        end else if (pos >= word_count) begin
          o.status = ST_BADIDX;
        end else begin
          o.word = words[pos];
        end
      end
      default: ;
    endcase
    o.cnt = CNT_W'(word_count);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outcome_q.delete();
      word_count   = 0;
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          report("result with no pending transaction", WORD_W'(status_i), '0);
        end else begin
          oldest = outcome_q.pop_front();
          if (status_i !== oldest.status)
            report("status", WORD_W'(status_i), WORD_W'(oldest.status));
          if (found_index_i !== oldest.found)
            report("found_index", WORD_W'(found_index_i), WORD_W'(oldest.found));
          if (read_value_i !== oldest.word)
            report("read_value", read_value_i, oldest.word);
          if (count_i !== oldest.cnt)
            report("count", WORD_W'(count_i), WORD_W'(oldest.cnt));
        end
      end
      if (start_i && !busy_i)
        outcome_q.push_back(predict_outcome(operation_i, index_i, value_i));
      pending_o = outcome_q.size();
    end
  end

endmodule

// ----- test/positional_array_insert_delete_search_test.sv -----
// ----------------------------------------------------------------------------
// Positional array testbench
// Drives clear, append, insert, delete, search and read transactions with
// random idle bursts: a directed opening, a fill to capacity, then random
// segments that grow, shrink or churn the array. The checker does the
// prediction and comparison; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module positional_array_insert_delete_search_test;

  timeunit 1ns;
  timeprecision 1ps;

  import posarr_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int SEGMENTS     = 17;
  localparam int SEG_ITEMS    = 40;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int TREND_GROW   = 0;
  localparam int TREND_SHRINK = 1;
  localparam int TREND_CHURN  = 2;

  localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;
  localparam logic [IDX_W-1:0]  IDX_TOP   = 7'd127;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  position;
  logic [WORD_W-1:0] word;
  logic              done;
  logic [ST_W-1:0]   status;
  logic [IDX_W-1:0]  found_index;
  logic [WORD_W-1:0] read_value;
  logic [CNT_W-1:0]  count;
  int                mismatches;
  int                pending;

  int                cycle_count;
  int                shadow_count;
  bit                idle_enabled;
  logic [WORD_W-1:0] key_pool [8];

  positional_array_insert_delete_search #(.DEPTH(DEPTH)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation),
    .index_i      (position),
    .value_i      (word),
    .done_o       (done),
    .status_o     (status),
    .found_index_o(found_index),
    .read_value_o (read_value),
    .count_o      (count)
  );

  positional_array_insert_delete_search_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .operation_i  (operation),
    .index_i      (position),
    .value_i      (word),
    .done_i       (done),
    .status_i     (status),
    .found_index_i(found_index),
    .read_value_i (read_value),
    .count_i      (count),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("positional_array_insert_delete_search test failed");
      $finish;
    end
  end

  function automatic int next_count(input logic [OP_W-1:0] op,
                                    input logic [IDX_W-1:0] idx, input int cnt);
    case (op)
      OP_CLEAR:  return 0;
      OP_APPEND: return (cnt < DEPTH) ? cnt + 1 : cnt;
      OP_INSERT: return (cnt < DEPTH && int'(idx) <= cnt) ? cnt + 1 : cnt;
      OP_DELETE: return (int'(idx) < cnt) ? cnt - 1 : cnt;
      default:   return cnt;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return key_pool[3'($urandom_range(0, 7))];
    if (r < 34) return '0;
    if (r < 38) return WORD_ONES;
    if (r < 42) return WORD_MIN;
    if (r < 46) return WORD_MAX;
    return $urandom;
  endfunction

  function automatic logic [WORD_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[3'($urandom_range(0, 7))];
    return pick_value();
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int trend);
    int w [7];
    int r;
    int k;
    case (trend)
      TREND_GROW:   w = '{1, 35, 30, 10, 10, 10, 4};
      TREND_SHRINK: w = '{2, 10, 10, 45, 15, 15, 3};
      default:      w = '{2, 20, 20, 20, 18, 18, 2};
    endcase
    r = $urandom_range(0, 99);
    for (k = 0; k < 6; k++) begin
      if (r < w[k]) return OP_W'(k);
      r -= w[k];
    end
    return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input logic [OP_W-1:0] op);
    if ($urandom_range(0, 99) < 15) return IDX_W'($urandom_range(0, 127));
    case (op)
      OP_INSERT:
        return IDX_W'($urandom_range(0, (shadow_count > 127) ? 127 : shadow_count));
      OP_DELETE, OP_READ:
        return (shadow_count == 0) ? IDX_W'($urandom_range(0, 127))
                                   : IDX_W'($urandom_range(0, shadow_count - 1));
      default: return IDX_W'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic idle(input int cycles);
    repeat (cycles) begin
      start     <= 1'b0;
      operation <= OP_W'($urandom);
      position  <= IDX_W'($urandom);
      word      <= $urandom;
      @(posedge clk_i);
    end
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [WORD_W-1:0] val);
    if (idle_enabled && $urandom_range(0, 4) == 0) idle($urandom_range(1, 17));
    start     <= 1'b1;
    operation <= op;
    position  <= idx;
    word      <= val;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    shadow_count = next_count(op, idx, shadow_count);
    if ((op == OP_APPEND || op == OP_INSERT) && $urandom_range(0, 2) == 0)
      key_pool[3'($urandom_range(0, 7))] = val;
  endtask

  initial begin
    int               seg;
    int               n;
    int               trend;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [WORD_W-1:0] val;

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    operation    <= OP_CLEAR;
    position     <= '0;
    word         <= '0;
    shadow_count = 0;
    idle_enabled = 1'b1;
    foreach (key_pool[k]) key_pool[k] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty array
    issue(OP_SEARCH, '0, WORD_MAX);
    issue(OP_READ, '0, '0);
    issue(OP_DELETE, IDX_TOP, '0);
    issue(OP_INSERT, 7'd1, WORD_ONES);
    // build: extremes, insert at front, at end and in the middle
    issue(OP_APPEND, '0, WORD_MAX);
    issue(OP_APPEND, '0, WORD_MIN);
    issue(OP_INSERT, '0, WORD_ONES);
    issue(OP_INSERT, 7'd3, '0);
    issue(OP_INSERT, 7'd2, 32'h5555_5555);
    issue(OP_READ, '0, '0);
    issue(OP_READ, 7'd4, '0);
    issue(OP_READ, 7'd5, '0);
    issue(OP_READ, IDX_TOP, WORD_ONES);
    issue(OP_SEARCH, '0, WORD_MIN);
    issue(OP_SEARCH, '0, 32'h1234_5678);
    issue(OP_APPEND, '0, WORD_MIN);
    issue(OP_SEARCH, IDX_TOP, WORD_MIN);
    issue(OP_DELETE, 7'd6, '0);
    issue(OP_DELETE, '0, '0);
    issue(OP_DELETE, 7'd4, '0);
    issue(OP_SPARE_LO, IDX_TOP, WORD_ONES);
    issue(OP_SPARE_HI, IDX_TOP, WORD_ONES);
    issue(OP_CLEAR, IDX_TOP, WORD_ONES);
    issue(OP_READ, '0, '0);

    // fill to capacity, then probe the full array
    while (shadow_count < DEPTH) begin
      if ($urandom_range(0, 1)) issue(OP_APPEND, IDX_W'($urandom), pick_value());
      else issue(OP_INSERT, IDX_W'($urandom_range(0, shadow_count)), pick_value());
    end
    issue(OP_APPEND, '0, WORD_MAX);
    issue(OP_INSERT, '0, WORD_MIN);
    issue(OP_INSERT, IDX_TOP, '0);
    issue(OP_SEARCH, '0, pick_key());
    issue(OP_READ, IDX_TOP, '0);
    issue(OP_DELETE, IDX_TOP, '0);
    issue(OP_INSERT, IDX_TOP, WORD_ONES);
    issue(OP_APPEND, '0, WORD_ONES);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (shadow_count < 16) trend = TREND_GROW;
      else trend = $urandom_range(TREND_GROW, TREND_CHURN);
      idle_enabled = (seg < SEGMENTS - 2) && ($urandom_range(0, 3) != 0);
      for (n = 0; n < SEG_ITEMS; n++) begin
        op  = pick_op(trend);
        idx = pick_index(op);
        val = (op == OP_SEARCH) ? pick_key() : pick_value();
        issue(op, idx, val);
      end
    end

    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("positional_array_insert_delete_search test passed");
    end else begin
      $display("positional_array_insert_delete_search test failed");
    end
    $finish;
  end

endmodule
